// ----- sv/mst_pkg.sv -----
// shared types, constants and helper functions of the multi-stage thermostat
// no dependencies; used by every module of the block
`default_nettype none

package mst_pkg;

    // block constants
    localparam int STAGES               = 3;
    localparam int LOW_SAMPLES_PER_STEP = 16;
    localparam int REPORT_INTERVAL      = 60;
    localparam int FIRST_ALARM_HOLDOFF  = 10;

    // field widths
    localparam int PAT_W      = 3;
    localparam int VAL_W      = 16;
    localparam int OFS_W      = 15;
    localparam int CTRL_W     = 3;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 8;
    localparam int AL_W       = 2;

    localparam logic [PAT_W-1:0] STAGE_MASK = PAT_W'((1 << STAGES) - 1);

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REP_ACK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOW_ACK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_HIGH_ACK = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_OFS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY  = 3'd7;

    // control bits
    localparam int CTRL_BINARY  = 0;
    localparam int CTRL_LOW_EN  = 1;
    localparam int CTRL_HIGH_EN = 2;

    // alarm machine states
    localparam logic [AL_W-1:0] AL_IDLE    = 2'd0;
    localparam logic [AL_W-1:0] AL_PENDING = 2'd1;
    localparam logic [AL_W-1:0] AL_SENT    = 2'd2;

    // configuration register set
    typedef struct packed {
        logic [VAL_W-1:0]  setpoint;
        logic [OFS_W-1:0]  hysteresis;
        logic [OFS_W-1:0]  deadband;
        logic [OFS_W-1:0]  low_ofs;
        logic [OFS_W-1:0]  high_ofs;
        logic [CTRL_W-1:0] control;
        logic [PAT_W-1:0]  max_pat;
        logic [VAL_W-1:0]  off_delay;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic [PAT_W-1:0] stage_outputs;
        logic             report_due;
        logic             low_alarm_due;
        logic             high_alarm_due;
    } t_result;

    // one step up of the stage pattern, taken only while the pattern is below the max pattern
    function automatic logic [PAT_W-1:0] add_stage(input logic [PAT_W-1:0] pat,
                                                   input logic [PAT_W-1:0] max_pat,
                                                   input logic             binary);
        logic [PAT_W-1:0] nxt;
        nxt = pat;
        if (pat < max_pat) begin
            if (binary) begin
                nxt = (pat + PAT_W'(1)) & STAGE_MASK;
            end else begin
                nxt = {pat[PAT_W-2:0], 1'b1} & STAGE_MASK;
            end
        end
        return nxt;
    endfunction

    // alarm machine step; returns {due, next state}
    function automatic logic [AL_W:0] alarm_step(input logic [AL_W-1:0] st,
                                                 input logic            trip,
                                                 input logic            clr);
        logic [AL_W:0] res;
        res = {1'b0, AL_IDLE};
        case (st)
            AL_PENDING: begin
                res = clr ? {1'b0, AL_IDLE} : {1'b1, AL_PENDING};
            end
            AL_SENT: begin
                res = clr ? {1'b0, AL_IDLE} : {1'b0, AL_SENT};
            end
            default: begin
                res = trip ? {1'b1, AL_PENDING} : {1'b0, AL_IDLE};
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mst_cfg.sv -----
// configuration register file of the multi-stage thermostat
// depends on mst_pkg
`default_nettype none

module mst_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mst_pkg::t_cfg                       o_cfg,
    output logic                                o_off_reload
);

    mst_pkg::t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint   <= 16'd6000;
            r_cfg.hysteresis <= 15'd500;
            r_cfg.deadband   <= 15'd80;
            r_cfg.low_ofs    <= 15'd1000;
            r_cfg.high_ofs   <= 15'd1000;
            r_cfg.control    <= '0;
            r_cfg.max_pat    <= mst_pkg::STAGE_MASK;
            r_cfg.off_delay  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mst_pkg::REG_SETPOINT:   r_cfg.setpoint   <= i_cfg_data;
                mst_pkg::REG_HYSTERESIS: r_cfg.hysteresis <= i_cfg_data[mst_pkg::OFS_W-1:0];
                mst_pkg::REG_DEADBAND:   r_cfg.deadband   <= i_cfg_data[mst_pkg::OFS_W-1:0];
                mst_pkg::REG_LOW_OFS:    r_cfg.low_ofs    <= i_cfg_data[mst_pkg::OFS_W-1:0];
                mst_pkg::REG_HIGH_OFS:   r_cfg.high_ofs   <= i_cfg_data[mst_pkg::OFS_W-1:0];
                mst_pkg::REG_CONTROL:    r_cfg.control    <= i_cfg_data[mst_pkg::CTRL_W-1:0];
                mst_pkg::REG_MAX_PAT: begin
                    // patterns beyond the stage count are dropped
                    if (i_cfg_data[mst_pkg::PAT_W-1:0] <= mst_pkg::STAGE_MASK) begin
                        r_cfg.max_pat <= i_cfg_data[mst_pkg::PAT_W-1:0];
                    end
                end
                mst_pkg::REG_OFF_DELAY:  r_cfg.off_delay  <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg        = r_cfg;
    // off delay write also reloads the turn-off countdown
    assign o_off_reload = i_cfg_we && (i_cfg_idx == mst_pkg::REG_OFF_DELAY);

endmodule

`default_nettype wire

// ----- sv/mst_core.sv -----
// thermostat state and single-pass next-state / result logic
// depends on mst_pkg; fed by mst_cfg, sequenced by the top level
`default_nettype none

module mst_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mst_pkg::t_cfg              i_cfg,
    input  wire logic                       i_off_reload,
    input  wire logic [mst_pkg::VAL_W-1:0]  i_off_value,
    input  wire logic                       i_en,
    input  wire logic [mst_pkg::FUNC_W-1:0] i_func,
    input  wire logic [mst_pkg::VAL_W-1:0]  i_value,
    output mst_pkg::t_result                o_result
);

    localparam int XW = mst_pkg::VAL_W + 2;

    logic [mst_pkg::VAL_W-1:0] r_last_value,   n_last_value;
    logic [mst_pkg::PAT_W-1:0] r_pat,          n_pat;
    logic [mst_pkg::CNT_W-1:0] r_low_cnt,      n_low_cnt;
    logic [mst_pkg::VAL_W-1:0] r_off_cnt,      n_off_cnt;
    logic [mst_pkg::VAL_W-1:0] r_rep_value,    n_rep_value;
    logic [mst_pkg::VAL_W-1:0] r_rep_setpoint, n_rep_setpoint;
    logic [mst_pkg::PAT_W-1:0] r_rep_pat,      n_rep_pat;
    logic [mst_pkg::VAL_W-1:0] r_rep_cnt,      n_rep_cnt;
    logic [mst_pkg::CNT_W-1:0] r_holdoff,      n_holdoff;
    logic [mst_pkg::AL_W-1:0]  r_low_st,       n_low_st;
    logic [mst_pkg::AL_W-1:0]  r_high_st,      n_high_st;

    logic signed [XW-1:0]      v_x, sp_x, on_x, lo_x, hi_x, diff_x, ndiff_x, db_x;
    logic [mst_pkg::CNT_W-1:0] low_inc;
    logic [mst_pkg::AL_W:0]    low_step, high_step;
    logic                      rep, lo, hi;

    // thresholds, widened so that no sum wraps
    always_comb begin
        v_x     = XW'($signed(i_value));
        sp_x    = XW'($signed(i_cfg.setpoint));
        on_x    = sp_x - $signed(XW'(i_cfg.hysteresis));
        lo_x    = sp_x - $signed(XW'(i_cfg.low_ofs));
        hi_x    = sp_x + $signed(XW'(i_cfg.high_ofs));
        diff_x  = v_x - XW'($signed(r_rep_value));
        ndiff_x = -diff_x;
        db_x    = $signed(XW'(i_cfg.deadband));
        low_inc = r_low_cnt + mst_pkg::CNT_W'(1);
    end

    // next state and result
    always_comb begin
        n_last_value   = r_last_value;
        n_pat          = r_pat;
        n_low_cnt      = r_low_cnt;
        n_off_cnt      = r_off_cnt;
        n_rep_value    = r_rep_value;
        n_rep_setpoint = r_rep_setpoint;
        n_rep_pat      = r_rep_pat;
        n_rep_cnt      = r_rep_cnt;
        n_holdoff      = r_holdoff;
        n_low_st       = r_low_st;
        n_high_st      = r_high_st;
        rep            = 1'b0;
        lo             = 1'b0;
        hi             = 1'b0;
        low_step       = '0;
        high_step      = '0;

        if (i_en) begin
            case (i_func)
                mst_pkg::FUNC_SAMPLE: begin
                    n_last_value = i_value;

                    // stage control with hysteresis
                    if (r_pat == '0) begin
                        if (v_x < on_x) begin
                            n_pat     = mst_pkg::add_stage(r_pat, i_cfg.max_pat,
                                                           i_cfg.control[mst_pkg::CTRL_BINARY]);
                            n_low_cnt = '0;
                        end
                    end else if (v_x < on_x) begin
                        n_low_cnt = low_inc;
                        if ((low_inc % mst_pkg::CNT_W'(mst_pkg::LOW_SAMPLES_PER_STEP)) == '0) begin
                            n_pat = mst_pkg::add_stage(r_pat, i_cfg.max_pat,
                                                       i_cfg.control[mst_pkg::CTRL_BINARY]);
                        end
                    end else if (v_x >= sp_x) begin
                        if (r_off_cnt != '0) begin
                            n_off_cnt = r_off_cnt - mst_pkg::VAL_W'(1);
                        end else begin
                            n_off_cnt = i_cfg.off_delay;
                            n_low_cnt = '0;
                            n_pat     = '0;
                        end
                    end

                    // report scheduling
                    if (r_rep_cnt[mst_pkg::VAL_W-1] || r_rep_cnt == '0) rep = 1'b1;
                    if (diff_x > db_x || ndiff_x > db_x)                rep = 1'b1;
                    if (i_cfg.setpoint != r_rep_setpoint)               rep = 1'b1;
                    if (n_pat != r_rep_pat)                             rep = 1'b1;
                    if (!r_rep_cnt[mst_pkg::VAL_W-1]) begin
                        n_rep_cnt = r_rep_cnt - mst_pkg::VAL_W'(1);
                    end

                    // alarms after the start-up holdoff
                    if (r_holdoff != '0) begin
                        n_holdoff = r_holdoff - mst_pkg::CNT_W'(1);
                    end else begin
                        low_step  = mst_pkg::alarm_step(r_low_st,
                                                        (v_x < lo_x) && (n_pat >= i_cfg.max_pat),
                                                        v_x > sp_x);
                        high_step = mst_pkg::alarm_step(r_high_st, v_x > hi_x, v_x < sp_x);
                        if (i_cfg.control[mst_pkg::CTRL_LOW_EN]) begin
                            lo       = low_step[mst_pkg::AL_W];
                            n_low_st = low_step[mst_pkg::AL_W-1:0];
                        end
                        if (i_cfg.control[mst_pkg::CTRL_HIGH_EN]) begin
                            hi        = high_step[mst_pkg::AL_W];
                            n_high_st = high_step[mst_pkg::AL_W-1:0];
                        end
                    end
                end
                mst_pkg::FUNC_REP_ACK: begin
                    n_rep_cnt      = mst_pkg::VAL_W'(mst_pkg::REPORT_INTERVAL);
                    n_rep_value    = r_last_value;
                    n_rep_setpoint = i_cfg.setpoint;
                    n_rep_pat      = r_pat;
                end
                mst_pkg::FUNC_LOW_ACK: begin
                    if (r_low_st == mst_pkg::AL_PENDING) n_low_st = mst_pkg::AL_SENT;
                end
                default: begin
                    if (r_high_st == mst_pkg::AL_PENDING) n_high_st = mst_pkg::AL_SENT;
                end
            endcase
        end

        // config write only while no item is in flight is up to the user; takes value written
        if (i_off_reload) begin
            n_off_cnt = i_off_value;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_value   <= '0;
            r_pat          <= '0;
            r_low_cnt      <= '0;
            r_off_cnt      <= '0;
            r_rep_value    <= '0;
            r_rep_setpoint <= '0;
            r_rep_pat      <= '0;
            r_rep_cnt      <= '0;
            r_holdoff      <= mst_pkg::CNT_W'(mst_pkg::FIRST_ALARM_HOLDOFF);
            r_low_st       <= mst_pkg::AL_IDLE;
            r_high_st      <= mst_pkg::AL_IDLE;
        end else begin
            r_last_value   <= n_last_value;
            r_pat          <= n_pat;
            r_low_cnt      <= n_low_cnt;
            r_off_cnt      <= n_off_cnt;
            r_rep_value    <= n_rep_value;
            r_rep_setpoint <= n_rep_setpoint;
            r_rep_pat      <= n_rep_pat;
            r_rep_cnt      <= n_rep_cnt;
            r_holdoff      <= n_holdoff;
            r_low_st       <= n_low_st;
            r_high_st      <= n_high_st;
        end
    end

    assign o_result.stage_outputs  = n_pat;
    assign o_result.report_due     = rep;
    assign o_result.low_alarm_due  = lo;
    assign o_result.high_alarm_due = hi;

endmodule

`default_nettype wire

// ----- sv/multi_stage_thermostat_unit.sv -----
// top level of the multi-stage thermostat: input register, core, result register
// depends on mst_pkg, mst_cfg and mst_core
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one word: i_func and
//   i_sample_value. func sample updates the stage pattern, report and alarm
//   flags; the three acknowledge codes mark the report or an alarm as sent.
//   output channel (o_out_valid / i_out_ready) returns one result word per
//   input word, in order: stage pattern plus report, low and high alarm flags.
//   path: an accepted word is held in the input register, then its result is
//   captured in the result register once that register is free or being read.
//   throughput: one word per cycle while the receiver takes each result; the
//   core evaluates a word combinationally between the input and result registers.
//   receiver stall: the result register holds; one more word is taken into
//   the input register, then o_in_ready drops until the result is taken.
//   reset (i_rst_n low, synchronous): both channels empty, registers at their
//   defaults, thermostat state cleared, alarm holdoff reloaded.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once;
//   write only while no word is in flight.
`default_nettype none

module multi_stage_thermostat_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [mst_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [mst_pkg::VAL_W-1:0]      i_sample_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [mst_pkg::PAT_W-1:0]           o_stage_outputs,
    output logic                                o_report_due,
    output logic                                o_low_alarm_due,
    output logic                                o_high_alarm_due
);

    mst_pkg::t_cfg             cfg;
    mst_pkg::t_result          core_res;
    logic                      off_reload;
    logic                      adv;

    logic                      r_in_valid;
    logic [mst_pkg::FUNC_W-1:0] r_in_func;
    logic [mst_pkg::VAL_W-1:0] r_in_value;
    logic                      r_out_valid;
    mst_pkg::t_result          r_out;

    // word moves from input register to result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    mst_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_cfg        (cfg),
        .o_off_reload (off_reload)
    );

    mst_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_off_reload (off_reload),
        .i_off_value  (i_cfg_data),
        .i_en         (adv),
        .i_func       (r_in_func),
        .i_value      (r_in_value),
        .o_result     (core_res)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func  <= i_func;
            r_in_value <= i_sample_value;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stage_outputs  = r_out.stage_outputs;
    assign o_report_due     = r_out.report_due;
    assign o_low_alarm_due  = r_out.low_alarm_due;
    assign o_high_alarm_due = r_out.high_alarm_due;

endmodule

`default_nettype wire

// ----- sv/mst_checker.sv -----
// port-level checks of the multi-stage thermostat, bound to the top level
// depends on mst_pkg and multi_stage_thermostat_unit
`default_nettype none

module mst_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [mst_pkg::PAT_W-1:0]  o_stage_outputs,
    input wire logic                       o_report_due,
    input wire logic                       o_low_alarm_due,
    input wire logic                       o_high_alarm_due
);

    // result channel comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result stays and holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_stage_outputs) &&
            $stable(o_report_due) && $stable(o_low_alarm_due) && $stable(o_high_alarm_due))
        else $error("stalled result changed");

    // input side only back-pressures while the receiver stalls a result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // a word accepted while the result side is empty passes the input register and shows up in the result register
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##1 o_out_valid)
        else $error("accepted word lost");

endmodule

bind multi_stage_thermostat_unit mst_checker u_mst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_stage_outputs  (o_stage_outputs),
    .o_report_due     (o_report_due),
    .o_low_alarm_due  (o_low_alarm_due),
    .o_high_alarm_due (o_high_alarm_due)
);

`default_nettype wire
